// ===== rtl/range_sensor_presence_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Range sensor presence filter assertion macros
// Concurrent assertion shorthands clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_SENSOR_PRESENCE_FILTER_ASSERT_SVH
`define RANGE_SENSOR_PRESENCE_FILTER_ASSERT_SVH
`ifndef SYNTH
// The condition holds at every clock edge.
`define RSPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define RSPF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define RSPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSPF_ASSERT_ALWAYS(label, cond, msg)
`define RSPF_ASSERT_IMPLIES(label, ante, cons, msg)
`define RSPF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/rspf_pkg.sv =====
// ----------------------------------------------------------------------------
// Range sensor presence filter package
// Widths, codes, word types and control structs shared across the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rspf_pkg;

    // Field widths
    localparam int DIST_W      = 13;
    localparam int FRAC_BITS   = 8;
    localparam int SMOOTH_W    = DIST_W + FRAC_BITS;
    localparam int CONF_W      = 8;
    localparam int NUM_SENSORS = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // Item kinds
    localparam logic [1:0] KIND_SAMPLE    = 2'd0;
    localparam logic [1:0] KIND_ENABLE    = 2'd1;
    localparam logic [1:0] KIND_DIRECTION = 2'd2;

    // Watch directions
    localparam logic [1:0] DIR_NONE     = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_CONF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CONF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT     = 3'd5;

    // Configuration reset values
    localparam logic [DIST_W-1:0]      NEAR_THR_RST     = 13'd150;
    localparam logic [DIST_W-1:0]      RELEASE_THR_RST  = 13'd250;
    localparam logic [CONF_W-1:0]      DETECT_CONF_RST  = 8'd3;
    localparam logic [CONF_W-1:0]      RELEASE_CONF_RST = 8'd3;
    localparam logic [DIST_W-1:0]      MAX_DIST_RST     = 13'd2000;
    localparam logic [NUM_SENSORS-1:0] PRESENT_RST      = 3'b111;

    // Input word
    typedef struct packed {
        logic [1:0]             kind;
        logic [DIST_W-1:0]      dist_front_left;
        logic [DIST_W-1:0]      dist_rear;
        logic [DIST_W-1:0]      dist_front_right;
        logic [NUM_SENSORS-1:0] phase_fail_mask;
        logic [NUM_SENSORS-1:0] timeout_mask;
        logic                   enable_value;
        logic [1:0]             direction_value;
    } item_t;

    // Result word
    typedef struct packed {
        logic obstacle_detected;
        logic all_sensors_valid;
        logic forward_zone_detected;
        logic rear_zone_detected;
    } result_t;

    // Controls from the top level to one sensor channel
    typedef struct packed {
        logic sample_en;
        logic smooth_en;
        logic clear_en;
    } sns_ctrl_t;

    // Status from one sensor channel
    typedef struct packed {
        logic valid;
        logic valid_next;
        logic is_near;
        logic is_clear;
    } sns_stat_t;

    // Controls from the top level to one zone debouncer
    typedef struct packed {
        logic step;
        logic clear;
    } zone_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rspf_ifs.sv =====
// ----------------------------------------------------------------------------
// Range sensor presence filter channels
// Valid/ready channels carrying one input word or one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rspf_item_if;
    import rspf_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rspf_result_if;
    import rspf_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rspf_sensor.sv =====
// ----------------------------------------------------------------------------
// Range sensor channel
// Qualifies one raw reading and keeps its half-weight exponential average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspf_sensor (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [rspf_pkg::DIST_W-1:0] raw,
    input  wire logic                   present,
    input  wire logic                   phase_fail,
    input  wire logic                   timed_out,
    input  wire logic [rspf_pkg::DIST_W-1:0] max_dist,
    input  wire logic [rspf_pkg::DIST_W-1:0] near_thr,
    input  wire logic [rspf_pkg::DIST_W-1:0] release_thr,
    input  wire rspf_pkg::sns_ctrl_t    ctrl,
    output rspf_pkg::sns_stat_t         stat
);
    import rspf_pkg::*;

    logic [DIST_W-1:0]   last_dist_reg;
    logic [DIST_W-1:0]   last_dist_next;
    logic                valid_reg;
    logic                valid_next;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [SMOOTH_W-1:0] smooth_next;
    logic                primed_reg;
    logic                primed_next;

    logic                qualify;
    logic                reading_bad;
    logic [SMOOTH_W-1:0] raw_fixed;
    logic [SMOOTH_W:0]   smooth_sum;

    // Reading qualification: a phase failure leaves the validity and the last distance untouched.
    always_comb
    begin
        qualify        = ctrl.sample_en && present && !phase_fail;
        reading_bad    = timed_out || (raw >= max_dist);
        valid_next     = qualify ? !reading_bad : valid_reg;
        last_dist_next = (qualify && !reading_bad) ? raw : last_dist_reg;
    end

    // Half-weight average in fixed point, truncating.
    always_comb
    begin
        raw_fixed  = {last_dist_next, {FRAC_BITS{1'b0}}};
        smooth_sum = {1'b0, raw_fixed} + {1'b0, smooth_reg};
        if (ctrl.smooth_en)
        begin
            primed_next = 1'b1;
            smooth_next = primed_reg ? smooth_sum[SMOOTH_W:1] : raw_fixed;
        end
        else if (ctrl.clear_en)
        begin
            primed_next = 1'b0;
            smooth_next = '0;
        end
        else
        begin
            primed_next = primed_reg;
            smooth_next = smooth_reg;
        end
    end

    // Threshold comparisons on the updated average.
    always_comb
    begin
        stat.valid      = valid_reg;
        stat.valid_next = valid_next;
        stat.is_near    = primed_next &&
                          (smooth_next <= {near_thr, {FRAC_BITS{1'b0}}});
        stat.is_clear   = !primed_next ||
                          (smooth_next >= {release_thr, {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dist_reg <= '0;
            valid_reg     <= 1'b0;
            smooth_reg    <= '0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            last_dist_reg <= last_dist_next;
            valid_reg     <= valid_next;
            smooth_reg    <= smooth_next;
            primed_reg    <= primed_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rspf_zone.sv =====
// ----------------------------------------------------------------------------
// Zone debouncer
// Confirms a zone as detected or released after set runs of samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspf_zone (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rspf_pkg::zone_ctrl_t        ctrl,
    input  wire logic                        candidate,
    input  wire logic                        zone_clear,
    input  wire logic [rspf_pkg::CONF_W-1:0] detect_conf,
    input  wire logic [rspf_pkg::CONF_W-1:0] release_conf,
    output logic                             detected,
    output logic                             detected_next
);
    import rspf_pkg::*;

    logic              detected_reg;
    logic [CONF_W-1:0] detect_cnt_reg;
    logic [CONF_W-1:0] detect_cnt_next;
    logic [CONF_W-1:0] release_cnt_reg;
    logic [CONF_W-1:0] release_cnt_next;
    logic [CONF_W-1:0] detect_cnt_inc;
    logic [CONF_W-1:0] release_cnt_inc;

    // Saturating counts; the counter stops at the confirmation figure.
    always_comb
    begin
        detect_cnt_inc  = (detect_cnt_reg < detect_conf) ?
                          detect_cnt_reg + CONF_W'(1) : detect_cnt_reg;
        release_cnt_inc = (release_cnt_reg < release_conf) ?
                          release_cnt_reg + CONF_W'(1) : release_cnt_reg;
    end

    // Detect and release debouncing.
    always_comb
    begin
        detected_next    = detected_reg;
        detect_cnt_next  = detect_cnt_reg;
        release_cnt_next = release_cnt_reg;
        if (ctrl.clear)
        begin
            detected_next    = 1'b0;
            detect_cnt_next  = '0;
            release_cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            if (!detected_reg)
            begin
                release_cnt_next = '0;
                if (candidate)
                begin
                    detect_cnt_next = detect_cnt_inc;
                    detected_next   = (detect_cnt_inc >= detect_conf);
                end
                else
                begin
                    detect_cnt_next = '0;
                end
            end
            else
            begin
                detect_cnt_next = '0;
                if (zone_clear)
                begin
                    release_cnt_next = release_cnt_inc;
                    detected_next    = !(release_cnt_inc >= release_conf);
                end
                else
                begin
                    release_cnt_next = '0;
                end
            end
        end
    end

    assign detected = detected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detected_reg    <= 1'b0;
            detect_cnt_reg  <= '0;
            release_cnt_reg <= '0;
        end
        else
        begin
            detected_reg    <= detected_next;
            detect_cnt_reg  <= detect_cnt_next;
            release_cnt_reg <= release_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/range_sensor_presence_filter.sv =====
// ----------------------------------------------------------------------------
// Range sensor presence filter
// Qualifies three range readings, smooths them and debounces two zones.
// ----------------------------------------------------------------------------
//  Port       Direction  Word      Handshake
//  item       sink       item_t    valid/ready
//  result     source     result_t  valid/ready
//  cfg_*      sink       13 bits   write enable, no back-pressure
//
//  Each word is fully processed in the cycle it is taken; the state updates at
//  that edge and its result word enters a two-entry output queue.
//  One word per cycle is sustained while results are taken; item.ready falls
//  only when both queue entries hold untaken results.
//  Reset clears all filter state and loads the default configuration.
//  A result is written to the output queue when its word is accepted and is shown once earlier results are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "range_sensor_presence_filter_assert.svh"

module range_sensor_presence_filter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    rspf_item_if.sink                             item,
    rspf_result_if.source                         result,
    input  wire logic                             cfg_we,
    input  wire logic [rspf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rspf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rspf_pkg::*;

    // Configuration registers
    logic [DIST_W-1:0]      near_thr_reg;
    logic [DIST_W-1:0]      release_thr_reg;
    logic [CONF_W-1:0]      detect_conf_reg;
    logic [CONF_W-1:0]      release_conf_reg;
    logic [DIST_W-1:0]      max_dist_reg;
    logic [NUM_SENSORS-1:0] present_reg;

    // Control state
    logic       monitor_reg;
    logic       monitor_next;
    logic [1:0] dir_reg;
    logic [1:0] dir_next;
    logic       obstacle_reg;
    logic       obstacle_next;

    // Output queue
    result_t    queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic       accept;
    logic       pop;
    logic       is_sample;
    logic       is_enable;
    logic       is_direction;
    logic       all_valid_now;
    logic       all_valid_next;
    logic [1:0] dir_in;
    logic       zone_fwd_next;
    logic       zone_rear_next;
    logic       zone_fwd;
    logic       zone_rear;
    result_t    result_next;

    logic [DIST_W-1:0] raw_dist [NUM_SENSORS];
    sns_ctrl_t         sns_ctrl;
    sns_stat_t         sns_stat [NUM_SENSORS];
    zone_ctrl_t        zone_ctrl;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_thr_reg     <= NEAR_THR_RST;
            release_thr_reg  <= RELEASE_THR_RST;
            detect_conf_reg  <= DETECT_CONF_RST;
            release_conf_reg <= RELEASE_CONF_RST;
            max_dist_reg     <= MAX_DIST_RST;
            present_reg      <= PRESENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEAR_THR:     near_thr_reg     <= cfg_data[DIST_W-1:0];
                CFG_RELEASE_THR:  release_thr_reg  <= cfg_data[DIST_W-1:0];
                CFG_DETECT_CONF:  detect_conf_reg  <= cfg_data[CONF_W-1:0];
                CFG_RELEASE_CONF: release_conf_reg <= cfg_data[CONF_W-1:0];
                CFG_MAX_DIST:     max_dist_reg     <= cfg_data[DIST_W-1:0];
                CFG_PRESENT:      present_reg      <= cfg_data[NUM_SENSORS-1:0];
                default:          ;
            endcase
        end
    end

    // Handshakes and word decoding
    assign item.ready   = (count_reg != 2'd2);
    assign accept       = item.valid && item.ready;
    assign pop          = result.valid && result.ready;
    assign is_sample    = accept && (item.data.kind == KIND_SAMPLE);
    assign is_enable    = accept && (item.data.kind == KIND_ENABLE);
    assign is_direction = accept && (item.data.kind == KIND_DIRECTION);

    assign raw_dist[0] = item.data.dist_front_left;
    assign raw_dist[1] = item.data.dist_rear;
    assign raw_dist[2] = item.data.dist_front_right;

    // Sensor channels
    always_comb
    begin
        all_valid_now  = sns_stat[0].valid && sns_stat[1].valid && sns_stat[2].valid;
        all_valid_next = sns_stat[0].valid_next && sns_stat[1].valid_next &&
                         sns_stat[2].valid_next;
        sns_ctrl.sample_en = is_sample && monitor_reg;
        sns_ctrl.smooth_en = is_sample && monitor_reg && all_valid_next;
        sns_ctrl.clear_en  = (is_sample && !(monitor_reg && all_valid_next)) ||
                             (is_enable && !item.data.enable_value);
    end

    for (genvar s = 0; s < NUM_SENSORS; s++)
    begin : g_sensor
        rspf_sensor u_sensor (
            .clk         (clk),
            .rst_n       (rst_n),
            .raw         (raw_dist[s]),
            .present     (present_reg[s]),
            .phase_fail  (item.data.phase_fail_mask[s]),
            .timed_out   (item.data.timeout_mask[s]),
            .max_dist    (max_dist_reg),
            .near_thr    (near_thr_reg),
            .release_thr (release_thr_reg),
            .ctrl        (sns_ctrl),
            .stat        (sns_stat[s])
        );
    end

    // Direction decode: the unused code means none.
    assign dir_in = ((item.data.direction_value == DIR_FORWARD) ||
                     (item.data.direction_value == DIR_BACKWARD)) ?
                    item.data.direction_value : DIR_NONE;

    // Zone debouncers
    always_comb
    begin
        zone_ctrl.step  = sns_ctrl.smooth_en;
        zone_ctrl.clear = sns_ctrl.clear_en || (is_direction && (dir_in == DIR_NONE));
    end

    rspf_zone u_zone_fwd (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (zone_ctrl),
        .candidate     (sns_stat[0].is_near || sns_stat[2].is_near),
        .zone_clear    (sns_stat[0].is_clear && sns_stat[2].is_clear),
        .detect_conf   (detect_conf_reg),
        .release_conf  (release_conf_reg),
        .detected      (zone_fwd),
        .detected_next (zone_fwd_next)
    );

    rspf_zone u_zone_rear (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (zone_ctrl),
        .candidate     (sns_stat[1].is_near),
        .zone_clear    (sns_stat[1].is_clear),
        .detect_conf   (detect_conf_reg),
        .release_conf  (release_conf_reg),
        .detected      (zone_rear),
        .detected_next (zone_rear_next)
    );

    // Enable, direction and obstacle flag.
    always_comb
    begin
        monitor_next  = monitor_reg;
        dir_next      = dir_reg;
        obstacle_next = obstacle_reg;
        if (is_sample)
        begin
            obstacle_next = 1'b0;
            if (sns_ctrl.smooth_en)
            begin
                if (dir_reg == DIR_FORWARD)
                begin
                    obstacle_next = zone_fwd_next;
                end
                else if (dir_reg == DIR_BACKWARD)
                begin
                    obstacle_next = zone_rear_next;
                end
            end
        end
        else if (is_enable)
        begin
            monitor_next = item.data.enable_value;
            if (!item.data.enable_value)
            begin
                obstacle_next = 1'b0;
                dir_next      = DIR_NONE;
            end
        end
        else if (is_direction)
        begin
            dir_next = dir_in;
            if (dir_in == DIR_NONE)
            begin
                obstacle_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_reg  <= 1'b0;
            dir_reg      <= DIR_NONE;
            obstacle_reg <= 1'b0;
        end
        else
        begin
            monitor_reg  <= monitor_next;
            dir_reg      <= dir_next;
            obstacle_reg <= obstacle_next;
        end
    end

    // Result word for the accepted item.
    always_comb
    begin
        result_next.obstacle_detected     = obstacle_next;
        result_next.all_sensors_valid     = all_valid_next;
        result_next.forward_zone_detected = zone_fwd_next;
        result_next.rear_zone_detected    = zone_rear_next;
    end

    // Two-entry output queue.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, pop};
        end
    end

    assign result.valid = (count_reg != 2'd0);
    assign result.data  = queue_reg[rd_ptr_reg];

    // Assertions
    `RSPF_ASSERT_ALWAYS(a_count_bound, count_reg != 2'd3, "output queue overfilled")
    `RSPF_ASSERT_IMPLIES(a_obstacle_dir, obstacle_reg, dir_reg != DIR_NONE, "no direction")
    `RSPF_ASSERT_IMPLIES(a_obstacle_mon, obstacle_reg, monitor_reg, "monitoring off")
    `RSPF_ASSERT_IMPLIES(a_zone_valid, zone_fwd || zone_rear, all_valid_now, "invalid sensor")
    `RSPF_ASSERT_NEXT(a_push_count, accept && !pop, count_reg == $past(count_reg) + 2'd1, "push")

endmodule

`default_nettype wire
